// File: rtl/core/signed_decimal_segment_formatter_unit_defines.svh
// ----------------------------------------------------------------------------
// signed decimal segment formatter assertion macros
// concurrent assertion helpers clocked on aclk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SIGNED_DECIMAL_SEGMENT_FORMATTER_UNIT_DEFINES_SVH
`define SIGNED_DECIMAL_SEGMENT_FORMATTER_UNIT_DEFINES_SVH

// property must hold at every edge out of reset
`define SDSF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("sdsf assertion failed");

// condition must never be seen out of reset
`define SDSF_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("sdsf forbidden condition seen");

`endif

// File: rtl/core/sdsf_pkg.sv
// ----------------------------------------------------------------------------
// sdsf_pkg
// shared widths, codes, segment tables and controller interface types
// ----------------------------------------------------------------------------
`default_nettype none

package sdsf_pkg;

    localparam int MAX_DIGITS  = 8;
    localparam int IDX_W       = 3;
    localparam int COUNT_W     = 4;
    localparam int VALUE_W     = 32;
    localparam int DEC_W       = 3;
    localparam int SEG_W       = 8;
    localparam int QUOT_W      = 29;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 4'd8;
    localparam logic [COUNT_W-1:0] COUNT_MIN   = 4'd1;

    localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
    localparam logic [SEG_W-1:0] SEG_MINUS = 8'h01;
    localparam logic [SEG_W-1:0] SEG_POINT = 8'h80;

    // divide by ten: q = (x * RECIP) >> 35, exact for all 32-bit x
    localparam logic [VALUE_W-1:0] RECIP = 32'hCCCC_CCCD;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_POINT = 2'd2
    } status_code_t;

    typedef struct packed {
        logic load;
        logic out_err;
        logic init_ext;
        logic mul;
        logic div;
        logic first_out;
        logic next_out;
    } sdsf_cmd_t;

    typedef struct packed {
        logic range_err;
        logic point_err;
        logic pos_zero;
        logic out_last;
    } sdsf_sts_t;

    function automatic logic [SEG_W-1:0] seg_of_digit(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0: s = 8'h7E;
            4'd1: s = 8'h30;
            4'd2: s = 8'h6D;
            4'd3: s = 8'h79;
            4'd4: s = 8'h33;
            4'd5: s = 8'h5B;
            4'd6: s = 8'h5F;
            4'd7: s = 8'h70;
            4'd8: s = 8'h7F;
            4'd9: s = 8'h7B;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    function automatic logic [VALUE_W-1:0] pow10_minus1(input logic [COUNT_W-1:0] k);
        logic [VALUE_W-1:0] v;
        case (k)
            4'd0: v = 32'd0;
            4'd1: v = 32'd9;
            4'd2: v = 32'd99;
            4'd3: v = 32'd999;
            4'd4: v = 32'd9999;
            4'd5: v = 32'd99999;
            4'd6: v = 32'd999999;
            4'd7: v = 32'd9999999;
            4'd8: v = 32'd99999999;
            default: v = 32'd99999999;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/sdsf_datapath.sv
// ----------------------------------------------------------------------------
// sdsf_datapath
// magnitude, range check, divide-by-ten digit extraction and segment output
// ----------------------------------------------------------------------------
`default_nettype none

module sdsf_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [sdsf_pkg::COUNT_W-1:0]      cfg_wr_data,
    input  wire logic [sdsf_pkg::VALUE_W-1:0]      in_value,
    input  wire logic [sdsf_pkg::DEC_W-1:0]        in_dec,
    input  wire logic                              in_point,
    input  wire sdsf_pkg::sdsf_cmd_t               cmd,
    output sdsf_pkg::sdsf_sts_t                    sts,
    output logic [sdsf_pkg::COUNT_W-1:0]           out_addr,
    output logic [sdsf_pkg::SEG_W-1:0]             out_seg,
    output sdsf_pkg::status_code_t                 out_status,
    output logic                                   out_last
);

    logic [sdsf_pkg::COUNT_W-1:0] digit_count_reg;
    logic [sdsf_pkg::VALUE_W-1:0] mag_reg;
    logic                         neg_reg;
    logic [sdsf_pkg::DEC_W-1:0]   dec_reg;
    logic                         point_reg;
    logic [sdsf_pkg::QUOT_W-1:0]  q_reg;
    logic [sdsf_pkg::IDX_W-1:0]   pos_reg;
    logic [sdsf_pkg::IDX_W-1:0]   lead_reg;
    logic                         any_nz_reg;
    logic [sdsf_pkg::IDX_W-1:0]   idx_reg;
    logic [3:0]                   dig_reg [sdsf_pkg::MAX_DIGITS];

    logic [sdsf_pkg::COUNT_W-1:0] n_eff;
    logic [sdsf_pkg::COUNT_W-1:0] n_eff_m1;
    logic [sdsf_pkg::IDX_W-1:0]   last_pos;
    logic [sdsf_pkg::VALUE_W-1:0] limit;
    logic [63:0]                  prod_full;
    logic [sdsf_pkg::VALUE_W-1:0] q_ext;
    logic [sdsf_pkg::VALUE_W-1:0] q_times10;
    logic [sdsf_pkg::VALUE_W-1:0] rem;
    logic [3:0]                   digit;
    logic [sdsf_pkg::IDX_W-1:0]   out_idx;
    logic [sdsf_pkg::IDX_W-1:0]   minus_pos;
    logic [sdsf_pkg::IDX_W-1:0]   point_pos;
    logic [sdsf_pkg::SEG_W-1:0]   seg_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_count_reg <= sdsf_pkg::COUNT_RESET;
        end else if (cfg_wr_en) begin
            digit_count_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        if (digit_count_reg < sdsf_pkg::COUNT_MIN) begin
            n_eff = sdsf_pkg::COUNT_MIN;
        end else if (digit_count_reg > sdsf_pkg::COUNT_MAX) begin
            n_eff = sdsf_pkg::COUNT_MAX;
        end else begin
            n_eff = digit_count_reg;
        end
    end

    assign n_eff_m1 = n_eff - 4'd1;
    assign last_pos = n_eff_m1[sdsf_pkg::IDX_W-1:0];

    assign limit = neg_reg ? sdsf_pkg::pow10_minus1(n_eff_m1) : sdsf_pkg::pow10_minus1(n_eff);

    assign sts.range_err = (mag_reg > limit);
    assign sts.point_err = point_reg && ({1'b0, dec_reg} > n_eff_m1);
    assign sts.pos_zero  = (pos_reg == '0);
    assign sts.out_last  = out_last;

    assign prod_full = 64'(mag_reg) * 64'(sdsf_pkg::RECIP);
    assign q_ext     = {3'b000, q_reg};
    assign q_times10 = (q_ext << 3) + (q_ext << 1);
    assign rem       = mag_reg - q_times10;
    assign digit     = rem[3:0];

    // extraction: mul and div alternate, one digit per pair, rightmost first
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mag_reg   <= in_value[sdsf_pkg::VALUE_W-1] ? (32'd0 - in_value) : in_value;
            neg_reg   <= in_value[sdsf_pkg::VALUE_W-1];
            dec_reg   <= in_dec;
            point_reg <= in_point;
        end else if (cmd.div) begin
            mag_reg <= q_ext;
        end

        if (cmd.mul) begin
            q_reg <= prod_full[63:35];
        end

        if (cmd.init_ext) begin
            pos_reg    <= last_pos;
            lead_reg   <= '0;
            any_nz_reg <= 1'b0;
        end else if (cmd.div) begin
            dig_reg[pos_reg] <= digit;
            pos_reg          <= pos_reg - 3'd1;
            if (digit != 4'd0) begin
                lead_reg   <= pos_reg;
                any_nz_reg <= 1'b1;
            end
        end
    end

    // segment pattern for the selected digit position
    assign out_idx   = cmd.next_out ? (idx_reg + 3'd1) : '0;
    assign minus_pos = (lead_reg == '0) ? '0 : (lead_reg - 3'd1);
    assign point_pos = last_pos - dec_reg;

    always_comb begin
        if (any_nz_reg) begin
            if (neg_reg && (out_idx == minus_pos)) begin
                seg_next = sdsf_pkg::SEG_MINUS;
            end else if (out_idx < lead_reg) begin
                seg_next = sdsf_pkg::SEG_BLANK;
            end else begin
                seg_next = sdsf_pkg::seg_of_digit(dig_reg[out_idx]);
            end
        end else if (out_idx == last_pos) begin
            seg_next = sdsf_pkg::seg_of_digit(4'd0);
        end else begin
            seg_next = sdsf_pkg::SEG_BLANK;
        end
        if (point_reg && (out_idx == point_pos)) begin
            seg_next = seg_next | sdsf_pkg::SEG_POINT;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_err) begin
            out_addr   <= '0;
            out_seg    <= sdsf_pkg::SEG_BLANK;
            out_status <= sts.range_err ? sdsf_pkg::STATUS_RANGE : sdsf_pkg::STATUS_POINT;
            out_last   <= 1'b1;
        end else if (cmd.first_out || cmd.next_out) begin
            idx_reg    <= out_idx;
            out_addr   <= {1'b0, out_idx} + 4'd1;
            out_seg    <= seg_next;
            out_status <= sdsf_pkg::STATUS_OK;
            out_last   <= (out_idx == last_pos);
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/sdsf_ctrl.sv
// ----------------------------------------------------------------------------
// sdsf_ctrl
// sequencer for check, digit extraction and per-digit result transfer
// ----------------------------------------------------------------------------
`default_nettype none

module sdsf_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output sdsf_pkg::sdsf_cmd_t      cmd,
    input  wire sdsf_pkg::sdsf_sts_t sts
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_SHOW  = 6'b010000,
        ST_WAIT  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.range_err || sts.point_err) begin
                    cmd.out_err = 1'b1;
                    state_next  = ST_WAIT;
                end else begin
                    cmd.init_ext = 1'b1;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div    = 1'b1;
                state_next = sts.pos_zero ? ST_SHOW : ST_MUL;
            end
            ST_SHOW: begin
                cmd.first_out = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (sts.out_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.next_out = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/signed_decimal_segment_formatter_unit.sv
// order: the input is checked; an error result is registered straight from the check, else
//   digits are extracted by alternating mul and div steps before the first result is registered
// one input at a time: the next is taken only after the last result transaction, as the shared
//   divide-by-ten multiplier serves every digit and each digit gives one result transaction
// reset: aresetn synchronous active low; digit count returns to 8, no transaction pending
// ----------------------------------------------------------------------------
// signed decimal segment formatter
// signed value to per-digit seven-segment writes with sign, blanking and point
// ----------------------------------------------------------------------------
`default_nettype none

module signed_decimal_segment_formatter_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [3:0]  cfg_wr_data,    // digit_count
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,        // value[31:0], decimal_places[34:32], zero pad
    input  wire logic [0:0]  s_tuser,        // point_on[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,        // digit_address[3:0], segment_byte[11:4], zero pad
    output logic [1:0]       m_tuser,        // status[1:0]
    output logic             m_tlast
);

    sdsf_pkg::sdsf_cmd_t    cmd;
    sdsf_pkg::sdsf_sts_t    sts;
    logic [3:0]             out_addr;
    logic [7:0]             out_seg;
    sdsf_pkg::status_code_t out_status;
    logic                   out_last;

    sdsf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .cmd     (cmd),
        .sts     (sts)
    );

    sdsf_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_value    (s_tdata[31:0]),
        .in_dec      (s_tdata[34:32]),
        .in_point    (s_tuser[0]),
        .cmd         (cmd),
        .sts         (sts),
        .out_addr    (out_addr),
        .out_seg     (out_seg),
        .out_status  (out_status),
        .out_last    (out_last)
    );

    assign m_tdata = {4'b0000, out_seg, out_addr};
    assign m_tuser = out_status;
    assign m_tlast = out_last;

endmodule

`default_nettype wire

// File: rtl/core/sdsf_checker.sv
// ----------------------------------------------------------------------------
// sdsf_checker
// port-level checks of the formatter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "signed_decimal_segment_formatter_unit_defines.svh"

module sdsf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_wr_en,
    input wire logic [3:0]  cfg_wr_data,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [39:0] s_tdata,
    input wire logic [0:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // stalled result transaction holds
    `SDSF_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

    // one item at a time: no input taken while results are offered
    `SDSF_ASSERT_NEVER(a_no_overlap, (s_tready && m_tvalid))

    // input transaction closes the input side for the next cycle
    `SDSF_ASSERT(a_busy_after_in, (s_tvalid && s_tready) |=> !s_tready)

    // error result is a single all-zero last transaction
    `SDSF_ASSERT(a_err_form, (m_tvalid && (m_tuser != sdsf_pkg::STATUS_OK)) |-> (m_tlast && (m_tdata == 16'd0)))

    // ok results address a real digit
    `SDSF_ASSERT(a_ok_addr, (m_tvalid && (m_tuser == sdsf_pkg::STATUS_OK)) |-> (m_tdata[3:0] != 4'd0))

endmodule

bind signed_decimal_segment_formatter_unit sdsf_checker u_sdsf_checker (.*);

`default_nettype wire
